FILE: rtl/core/ellipse_rasterizer_unit_defines.svh
// Assertion macros shared by the ellipse rasterizer checkers.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef ELLIPSE_RASTERIZER_UNIT_DEFINES_SVH
`define ELLIPSE_RASTERIZER_UNIT_DEFINES_SVH

// Plain property, sampled on the rising clock, off while in reset
`define ER_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ellipse rasterizer check failed");

// A stalled transaction keeps valid high and its payload unchanged
`define ER_ASSERT_HOLD(lbl, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
		else $error("ellipse rasterizer stalled output changed");

`endif

FILE: rtl/core/er_pkg.sv
// Package for the ellipse rasterizer: shared constants, command/status
// structs and small arithmetic helpers. No dependencies.
package er_pkg;

	localparam int WORD_W = 32;

	// action codes of an input transaction
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;
		logic mul_a2;
		logic mul_b2;
		logic mul_ba;
		logic setup;
		logic r1_step;
		logic tr1;
		logic tr2;
		logic r2_step;
	} er_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic degen;
		logic ph_idle;
		logic ph_r1;
		logic r1_go;
	} er_status_t;

	// signed less-than on 32-bit two's complement words
	function automatic logic slt32(input logic [WORD_W-1:0] p, input logic [WORD_W-1:0] q);
		return $signed(p) < $signed(q);
	endfunction

	// divide by 4, rounding toward zero
	function automatic logic [WORD_W-1:0] div4_trunc(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] t;
		t = v + (v[WORD_W-1] ? WORD_W'(3) : WORD_W'(0));
		return {{2{t[WORD_W-1]}}, t[WORD_W-1:2]};
	endfunction

endpackage

FILE: rtl/core/er_in_if.sv
// Input channel of the ellipse rasterizer: valid/ready plus command payload.
// Depends on nothing.
interface er_in_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [COORD_BITS-1:0] corner_x0;
	logic [COORD_BITS-1:0] corner_y0;
	logic [COORD_BITS-1:0] corner_x1;
	logic [COORD_BITS-1:0] corner_y1;
	logic                  fill_mode;
	logic [31:0]           color;

	modport source (output valid, action, corner_x0, corner_y0, corner_x1, corner_y1,
		fill_mode, color, input ready);
	modport sink (input valid, action, corner_x0, corner_y0, corner_x1, corner_y1,
		fill_mode, color, output ready);
endinterface

FILE: rtl/core/er_out_if.sv
// Output channel of the ellipse rasterizer: valid/ready plus pixel or span payload.
// Depends on nothing.
interface er_out_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic                  emit;
	logic                  done_res;
	logic [COORD_BITS-1:0] left_x;
	logic [COORD_BITS-1:0] right_x;
	logic [COORD_BITS-1:0] upper_row;
	logic [COORD_BITS-1:0] lower_row;
	logic                  is_span;
	logic [31:0]           pixel_color;

	modport source (output valid, emit, done_res, left_x, right_x, upper_row, lower_row,
		is_span, pixel_color, input ready);
	modport sink (input valid, emit, done_res, left_x, right_x, upper_row, lower_row,
		is_span, pixel_color, output ready);
endinterface

FILE: rtl/core/ellipse_rasterizer_unit.sv
// Top level of the ellipse rasterizer; depends on er_pkg, er_in_if, er_out_if,
// er_ctrl and er_datapath.
// Start: taken in ST_WAIT, then three shared multiplies and one setup step before the next
// transaction; a single-point box skips setup. Advance: registered in ST_R1 or ST_R2
// (leaving region one runs ST_TR1 and ST_TR2 first), offered in ST_OUT; no new step is
// taken before the output handshake. Reset: arst_n clears FSM and phase to idle.
module ellipse_rasterizer_unit #(
	parameter int COORD_BITS = 10
) (
	input logic         clk,
	input logic         arst_n,
	er_in_if.sink       in_ch,
	er_out_if.source    out_ch
);
	import er_pkg::*;

	er_cmd_t    cmd;
	er_status_t status;

	er_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	er_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_x0       (in_ch.corner_x0),
		.in_y0       (in_ch.corner_y0),
		.in_x1       (in_ch.corner_x1),
		.in_y1       (in_ch.corner_y1),
		.in_fill     (in_ch.fill_mode),
		.in_color    (in_ch.color),
		.emit        (out_ch.emit),
		.done_res    (out_ch.done_res),
		.left_x      (out_ch.left_x),
		.right_x     (out_ch.right_x),
		.upper_row   (out_ch.upper_row),
		.lower_row   (out_ch.lower_row),
		.is_span     (out_ch.is_span),
		.pixel_color (out_ch.pixel_color)
	);

endmodule

FILE: rtl/core/er_ctrl.sv
// Controller FSM of the ellipse rasterizer: sequences setup multiplies,
// region steps and the output handshake. Depends on er_pkg.
module er_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  er_pkg::er_status_t status,
	output er_pkg::er_cmd_t   cmd
);
	import er_pkg::*;

	typedef enum logic [9:0] {
		ST_WAIT   = 10'b00_0000_0001,
		ST_MUL_A2 = 10'b00_0000_0010,
		ST_MUL_B2 = 10'b00_0000_0100,
		ST_MUL_BA = 10'b00_0000_1000,
		ST_SETUP  = 10'b00_0001_0000,
		ST_R1     = 10'b00_0010_0000,
		ST_TR1    = 10'b00_0100_0000,
		ST_TR2    = 10'b00_1000_0000,
		ST_R2     = 10'b01_0000_0000,
		ST_OUT    = 10'b10_0000_0000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_WAIT: begin
				if (in_valid) begin
					if (in_action == ACT_START) begin
						cmd.capture = 1'b1;
						if (!status.degen)
							state_d = ST_MUL_A2;
					end else if (status.ph_r1) begin
						state_d = ST_R1;
					end else if (!status.ph_idle) begin
						state_d = ST_R2;
					end
				end
			end
			ST_MUL_A2: begin
				cmd.mul_a2 = 1'b1;
				state_d    = ST_MUL_B2;
			end
			ST_MUL_B2: begin
				cmd.mul_b2 = 1'b1;
				state_d    = ST_MUL_BA;
			end
			ST_MUL_BA: begin
				cmd.mul_ba = 1'b1;
				state_d    = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_R1: begin
				cmd.r1_step = 1'b1;
				state_d     = status.r1_go ? ST_OUT : ST_TR1;
			end
			ST_TR1: begin
				cmd.tr1 = 1'b1;
				state_d = ST_TR2;
			end
			ST_TR2: begin
				cmd.tr2 = 1'b1;
				state_d = ST_R2;
			end
			ST_R2: begin
				cmd.r2_step = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready)
					state_d = ST_WAIT;
			end
			default: state_d = ST_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_WAIT;
		else
			state_q <= state_d;
	end

	assign in_ready  = (state_q == ST_WAIT);
	assign out_valid = (state_q == ST_OUT);

endmodule

FILE: rtl/core/er_datapath.sv
// Datapath of the ellipse rasterizer: box capture, shared setup multiplier,
// midpoint decision terms and the registered result. Depends on er_pkg.
module er_datapath #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  er_pkg::er_cmd_t       cmd,
	output er_pkg::er_status_t    status,
	input  logic [COORD_BITS-1:0] in_x0,
	input  logic [COORD_BITS-1:0] in_y0,
	input  logic [COORD_BITS-1:0] in_x1,
	input  logic [COORD_BITS-1:0] in_y1,
	input  logic                  in_fill,
	input  logic [31:0]           in_color,
	output logic                  emit,
	output logic                  done_res,
	output logic [COORD_BITS-1:0] left_x,
	output logic [COORD_BITS-1:0] right_x,
	output logic [COORD_BITS-1:0] upper_row,
	output logic [COORD_BITS-1:0] lower_row,
	output logic                  is_span,
	output logic [31:0]           pixel_color
);
	import er_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int XW = CW + 1;
	localparam int YW = CW + 2;
	localparam int MW = WORD_W + CW;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_R1   = 3'b010,
		PH_R2   = 3'b100
	} phase_t;

	phase_t phase_q;

	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;
	logic [YW-1:0]     prev_q;
	logic [CW-1:0]     a_q;
	logic [CW-1:0]     box_l_q, box_t_q, box_r_q, box_b_q;
	logic              fill_q;
	logic [31:0]       color_q;
	logic [WORD_W-1:0] d_q, fn_q, fnw_q, fw_q;
	logic [WORD_W-1:0] a8_q, b8_q, b2_q, a2b2_q;
	logic [WORD_W-1:0] a2_q, b2a_q;

	logic          res_emit_q, res_done_q, res_span_q;
	logic [CW-1:0] res_left_q, res_right_q, res_upper_q, res_lower_q;

	// corner ordering on the incoming command
	logic [CW-1:0] lo_x, hi_x, lo_y, hi_y, half_w, half_h;
	logic          degen;

	always_comb begin
		lo_x   = (in_x1 < in_x0) ? in_x1 : in_x0;
		hi_x   = (in_x1 < in_x0) ? in_x0 : in_x1;
		lo_y   = (in_y1 < in_y0) ? in_y1 : in_y0;
		hi_y   = (in_y1 < in_y0) ? in_y0 : in_y1;
		half_w = (hi_x - lo_x) >> 1;
		half_h = (hi_y - lo_y) >> 1;
		degen  = (in_x0 == in_x1) && (in_y0 == in_y1);
	end

	// shared setup multiplier, product kept modulo 2^32
	logic [WORD_W-1:0] mul_op1, mul_p;
	logic [CW-1:0]     mul_op2;
	logic [MW-1:0]     mul_full;

	always_comb begin
		mul_op1 = WORD_W'(a_q);
		mul_op2 = a_q;
		if (cmd.mul_b2) begin
			mul_op1 = WORD_W'(y_q[CW-1:0]);
			mul_op2 = y_q[CW-1:0];
		end else if (cmd.mul_ba) begin
			mul_op1 = b2_q;
			mul_op2 = a_q;
		end
		mul_full = MW'(mul_op1) * MW'(mul_op2);
		mul_p    = mul_full[WORD_W-1:0];
	end

	// initial forward differences
	logic [WORD_W-1:0] s_a4, s_a8, s_b8, s_fnw, s_d;

	always_comb begin
		s_a4  = a2_q << 2;
		s_a8  = a2_q << 3;
		s_b8  = b2_q << 3;
		s_fnw = s_a8 + s_a4 - (b2a_q << 3) + s_b8;
		s_d   = b2_q - (b2a_q << 2) + s_a4;
	end

	// region one decision and region two transition terms
	logic [WORD_W-1:0] a4r, b4r, diff, tr_sum;
	logic              y_pos, r1_go, r1_vert;

	always_comb begin
		a4r     = a8_q >> 1;
		b4r     = b8_q >> 1;
		diff    = fnw_q - fn_q;
		y_pos   = (y_q != '0) && !y_q[YW-1];
		r1_vert = d_q[WORD_W-1] || slt32(b2_q, diff);
		r1_go   = slt32(fnw_q, a2b2_q) || d_q[WORD_W-1] || (slt32(b2_q, diff) && y_pos);
		tr_sum  = (fw_q << 1) - (fn_q << 1) + a4r + b4r + a8_q;
	end

	// region two checks
	logic r2_over, r2_last, r2_emit;

	always_comb begin
		r2_over = x_q > XW'(a_q);
		r2_last = x_q == XW'(a_q);
		r2_emit = !fill_q || (y_q != prev_q);
	end

	// pixel coordinates at the current offsets
	logic [CW-1:0] pix_l, pix_r, pix_u, pix_d;

	always_comb begin
		pix_l = box_l_q + x_q[CW-1:0];
		pix_r = box_r_q - x_q[CW-1:0];
		pix_u = box_t_q + y_q[CW-1:0];
		pix_d = box_b_q - y_q[CW-1:0];
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			if (cmd.capture)
				phase_q <= PH_IDLE;
			else if (cmd.setup)
				phase_q <= PH_R1;
			else if (cmd.tr2)
				phase_q <= PH_R2;
			else if (cmd.r2_step && (r2_over || r2_last))
				phase_q <= PH_IDLE;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			box_l_q <= lo_x;
			box_t_q <= lo_y;
			box_r_q <= hi_x;
			box_b_q <= hi_y;
			fill_q  <= in_fill;
			color_q <= in_color;
			if (!degen) begin
				a_q <= half_w;
				x_q <= '0;
				y_q <= YW'(half_h);
			end
		end
		if (cmd.mul_a2)
			a2_q <= mul_p;
		if (cmd.mul_b2)
			b2_q <= mul_p;
		if (cmd.mul_ba)
			b2a_q <= mul_p;
		if (cmd.setup) begin
			a8_q   <= s_a8;
			b8_q   <= s_b8;
			a2b2_q <= a2_q + b2_q;
			fn_q   <= s_a8 + s_a4;
			fnw_q  <= s_fnw;
			fw_q   <= '0;
			d_q    <= s_d;
		end
		if (cmd.r1_step && r1_go) begin
			y_q  <= y_q - YW'(1);
			fn_q <= fn_q + a8_q;
			if (r1_vert) begin
				d_q   <= d_q + fn_q;
				fnw_q <= fnw_q + a8_q;
			end else begin
				x_q   <= x_q + XW'(1);
				d_q   <= d_q + fnw_q;
				fnw_q <= fnw_q + a8_q + b8_q;
			end
		end
		if (cmd.tr1) begin
			fw_q   <= diff + b4r;
			fnw_q  <= fnw_q + b4r - a4r;
			prev_q <= y_q + YW'(1);
		end
		if (cmd.tr2)
			d_q <= d_q + div4_trunc(tr_sum);
		if (cmd.r2_step && !r2_over) begin
			prev_q <= y_q;
			x_q    <= x_q + XW'(1);
			fw_q   <= fw_q + b8_q;
			if (d_q[WORD_W-1]) begin
				y_q   <= y_q - YW'(1);
				d_q   <= d_q + fnw_q;
				fnw_q <= fnw_q + a8_q + b8_q;
			end else begin
				d_q   <= d_q + fw_q;
				fnw_q <= fnw_q + b8_q;
			end
		end
	end

	// result register
	logic res_load, res_emit_d, res_done_d;

	always_comb begin
		res_load   = (cmd.r1_step && r1_go) || cmd.r2_step;
		res_emit_d = cmd.r1_step ? 1'b1 : (!r2_over && r2_emit);
		res_done_d = cmd.r2_step && (r2_over || r2_last);
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_emit_q  <= res_emit_d;
			res_done_q  <= res_done_d;
			res_span_q  <= res_emit_d && fill_q;
			res_left_q  <= res_emit_d ? pix_l : '0;
			res_right_q <= res_emit_d ? pix_r : '0;
			res_upper_q <= res_emit_d ? pix_u : '0;
			res_lower_q <= res_emit_d ? pix_d : '0;
		end
	end

	assign status.degen   = degen;
	assign status.ph_idle = (phase_q == PH_IDLE);
	assign status.ph_r1   = (phase_q == PH_R1);
	assign status.r1_go   = r1_go;

	assign emit        = res_emit_q;
	assign done_res    = res_done_q;
	assign left_x      = res_left_q;
	assign right_x     = res_right_q;
	assign upper_row   = res_upper_q;
	assign lower_row   = res_lower_q;
	assign is_span     = res_span_q;
	assign pixel_color = color_q;

endmodule

FILE: rtl/core/er_checker.sv
// Port-level checker for the ellipse rasterizer and its bind to the top level.
// Depends on er_pkg and ellipse_rasterizer_unit_defines.svh.
`include "ellipse_rasterizer_unit_defines.svh"

module er_checker #(
	parameter int COORD_BITS = 10
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_action,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  emit,
	input logic                  done_res,
	input logic [COORD_BITS-1:0] left_x,
	input logic [COORD_BITS-1:0] right_x,
	input logic [COORD_BITS-1:0] upper_row,
	input logic [COORD_BITS-1:0] lower_row,
	input logic                  is_span,
	input logic [31:0]           pixel_color
);
	import er_pkg::*;

	logic [4*COORD_BITS+34:0] out_pack;
	logic                     coords_zero;

	assign out_pack = {emit, done_res, left_x, right_x, upper_row, lower_row, is_span,
		pixel_color};

	assign coords_zero = (left_x == '0) && (right_x == '0) && (upper_row == '0) &&
		(lower_row == '0) && !is_span;

	// one transaction in flight: nothing taken while a result waits
	`ER_ASSERT(a_no_accept_while_result, out_valid |-> !in_ready)
	// a start command never yields a result
	`ER_ASSERT(a_start_silent, (in_valid && in_ready && in_action == ACT_START) |=> !out_valid)
	// an empty step carries zero coordinates
	`ER_ASSERT(a_empty_is_zero, (out_valid && !emit) |-> coords_zero)
	// stalled result holds
	`ER_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_pack)

endmodule

bind ellipse_rasterizer_unit er_checker #(.COORD_BITS(COORD_BITS)) u_er_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_action   (in_ch.action),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.emit        (out_ch.emit),
	.done_res    (out_ch.done_res),
	.left_x      (out_ch.left_x),
	.right_x     (out_ch.right_x),
	.upper_row   (out_ch.upper_row),
	.lower_row   (out_ch.lower_row),
	.is_span     (out_ch.is_span),
	.pixel_color (out_ch.pixel_color)
);

FILE: bench/ellipse_rasterizer_unit_test.sv
// Self-checking bench for ellipse_rasterizer_unit: directed table, then random commands.
// Depends on er_pkg, er_in_if, er_out_if and the ellipse_rasterizer_unit RTL.
`timescale 1ns / 1ps

module ellipse_rasterizer_unit_test;
	import er_pkg::*;

	localparam int COORD_BITS  = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic        action;
		logic [9:0]  corner_x0;
		logic [9:0]  corner_y0;
		logic [9:0]  corner_x1;
		logic [9:0]  corner_y1;
		logic        fill_mode;
		logic [31:0] color;
	} draw_cmd_t;

	typedef struct packed {
		logic        emit;
		logic        done_res;
		logic [9:0]  left_x;
		logic [9:0]  right_x;
		logic [9:0]  upper_row;
		logic [9:0]  lower_row;
		logic        is_span;
		logic [31:0] pixel_color;
	} pix_res_t;

	typedef struct {
		draw_cmd_t cmd;
		bit        typed;
		bit        has_res;
		pix_res_t  res;
	} dir_row_t;

	typedef enum logic [1:0] {ELL_IDLE, ELL_R1, ELL_R2} ell_phase_t;

	logic clk;
	logic arst_n;

	er_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
	er_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

	ellipse_rasterizer_unit #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// rasterizer state shadow
	ell_phase_t  ell_phase;
	logic [10:0] pos_x;
	logic [11:0] pos_y;
	logic [9:0]  half_w;
	logic [9:0]  box_l, box_t, box_r, box_b;
	logic [31:0] err_term;
	logic [31:0] term_n, term_nw, term_w;
	logic [31:0] inc_a8, inc_b8, inc_b2, inc_a2b2;
	logic [11:0] last_row;
	logic        fill_on;
	logic [31:0] cur_color;

	pix_res_t pix_expected[$];
	dir_row_t dir_rows[$];

	int errors;
	int items_used;
	int results_seen;
	int spans_seen;
	int finishes_seen;
	int cycle_cnt;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_reqs;
	int holds_served;
	int hold_left;

	always #5 clk = ~clk;

	function automatic void ell_reset();
		ell_phase = ELL_IDLE;
		pos_x = '0;
		pos_y = '0;
		half_w = '0;
		{box_l, box_t, box_r, box_b} = '0;
		err_term = '0;
		{term_n, term_nw, term_w} = '0;
		{inc_a8, inc_b8, inc_b2, inc_a2b2} = '0;
		last_row = '0;
		fill_on = 1'b0;
		cur_color = '0;
	endfunction

	// divide by 4 with rounding toward zero
	function automatic logic [31:0] quarter(input logic [31:0] v);
		logic [31:0] mag;
		mag = v[31] ? -v : v;
		mag = mag >> 2;
		return v[31] ? -mag : mag;
	endfunction

	function automatic pix_res_t ell_pixel(input bit emit, input bit done_res);
		pix_res_t r;
		r = '0;
		r.emit = emit;
		r.done_res = done_res;
		r.pixel_color = cur_color;
		if (emit) begin
			r.left_x    = box_l + pos_x[9:0];
			r.right_x   = box_r - pos_x[9:0];
			r.upper_row = box_t + pos_y[9:0];
			r.lower_row = box_b - pos_y[9:0];
			r.is_span   = fill_on;
		end
		return r;
	endfunction

	// order the corners and set up the forward differences
	function automatic void ell_start(input draw_cmd_t c);
		logic [9:0]  x0, x1, y0, y1, t;
		logic [31:0] a, b, a2, b2;
		x0 = c.corner_x0;
		x1 = c.corner_x1;
		y0 = c.corner_y0;
		y1 = c.corner_y1;
		if (x1 < x0) begin
			t = x0; x0 = x1; x1 = t;
		end
		if (y1 < y0) begin
			t = y0; y0 = y1; y1 = t;
		end
		fill_on = c.fill_mode;
		cur_color = c.color;
		box_l = x0; box_t = y0; box_r = x1; box_b = y1;
		if (x0 == x1 && y0 == y1) begin
			ell_phase = ELL_IDLE;
			return;
		end
		a = {22'd0, x1 - x0} >> 1;
		b = {22'd0, y1 - y0} >> 1;
		a2 = a * a;
		b2 = b * b;
		half_w = a[9:0];
		pos_x = '0;
		pos_y = b[11:0];
		inc_a8 = a2 * 8;
		inc_b8 = b2 * 8;
		inc_b2 = b2;
		inc_a2b2 = a2 + b2;
		term_n = a2 * 8 + a2 * 4;
		term_nw = a2 * 8 + a2 * 4 - b2 * 8 * a + b2 * 8;
		term_w = '0;
		err_term = b2 - b2 * 4 * a + a2 * 4;
		ell_phase = ELL_R1;
	endfunction

	function automatic pix_res_t ell_region2();
		pix_res_t r;
		bit       emit;
		if (pos_x > {1'b0, half_w}) begin
			ell_phase = ELL_IDLE;
			return ell_pixel(1'b0, 1'b1);
		end
		// a filled row drawn already is skipped
		emit = !fill_on || (pos_y != last_row);
		r = ell_pixel(emit, 1'b0);
		last_row = pos_y;
		pos_x = pos_x + 11'd1;
		if (err_term[31]) begin
			pos_y = pos_y - 12'd1;
			err_term = err_term + term_nw;
			term_w = term_w + inc_b8;
			term_nw = term_nw + inc_a8 + inc_b8;
		end else begin
			err_term = err_term + term_w;
			term_w = term_w + inc_b8;
			term_nw = term_nw + inc_b8;
		end
		if (pos_x > {1'b0, half_w}) begin
			ell_phase = ELL_IDLE;
			r.done_res = 1'b1;
		end
		return r;
	endfunction

	function automatic pix_res_t ell_region1();
		pix_res_t    r;
		logic [31:0] a4, b4, d, diff, w_new, total;
		bit          go, steep;
		a4 = inc_a8 >> 1;
		b4 = inc_b8 >> 1;
		d = err_term;
		diff = term_nw - term_n;
		steep = $signed(inc_b2) < $signed(diff);
		go = ($signed(term_nw) < $signed(inc_a2b2)) || d[31] ||
			(steep && pos_y != 0 && !pos_y[11]);
		if (go) begin
			r = ell_pixel(1'b1, 1'b0);
			pos_y = pos_y - 12'd1;
			if (d[31] || steep) begin
				err_term = d + term_n;
				term_n = term_n + inc_a8;
				term_nw = term_nw + inc_a8;
			end else begin
				pos_x = pos_x + 11'd1;
				err_term = d + term_nw;
				term_n = term_n + inc_a8;
				term_nw = term_nw + inc_a8 + inc_b8;
			end
			return r;
		end
		// hand over to region two and run its first iteration
		w_new = term_nw - term_n + b4;
		total = w_new + w_new - term_n - term_n + a4 + b4 + inc_a8;
		term_w = w_new;
		err_term = d + quarter(total);
		term_nw = term_nw + b4 - a4;
		last_row = pos_y + 12'd1;
		ell_phase = ELL_R2;
		return ell_region2();
	endfunction

	function automatic bit ell_apply(input draw_cmd_t c, output pix_res_t r);
		r = '0;
		if (c.action == ACT_START) begin
			ell_start(c);
			return 1'b0;
		end
		case (ell_phase)
			ELL_R1: begin
				r = ell_region1();
				return 1'b1;
			end
			ELL_R2: begin
				r = ell_region2();
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic draw_cmd_t mk_cmd(input logic action, input int x0, input int y0,
		input int x1, input int y1, input logic fill, input logic [31:0] color);
		draw_cmd_t c;
		c.action = action;
		c.corner_x0 = x0[9:0];
		c.corner_y0 = y0[9:0];
		c.corner_x1 = x1[9:0];
		c.corner_y1 = y1[9:0];
		c.fill_mode = fill;
		c.color = color;
		return c;
	endfunction

	function automatic pix_res_t mk_pix(input bit emit, input bit done_res, input int lx,
		input int rx, input int up, input int lo, input bit span, input logic [31:0] color);
		pix_res_t r;
		r.emit = emit;
		r.done_res = done_res;
		r.left_x = lx[9:0];
		r.right_x = rx[9:0];
		r.upper_row = up[9:0];
		r.lower_row = lo[9:0];
		r.is_span = span;
		r.pixel_color = color;
		return r;
	endfunction

	function automatic void add_row(input draw_cmd_t c, input bit typed, input bit has_res,
		input pix_res_t res);
		dir_row_t row;
		row.cmd = c;
		row.typed = typed;
		row.has_res = has_res;
		row.res = res;
		dir_rows.push_back(row);
	endfunction

	function automatic draw_cmd_t rand_step();
		draw_cmd_t c;
		c = mk_cmd(ACT_STEP, $urandom_range(1023), $urandom_range(1023),
			$urandom_range(1023), $urandom_range(1023), $urandom_range(1), $urandom);
		return c;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// offer one transaction, wait for it to be taken, then predict
	task automatic send_cmd(input draw_cmd_t c, input bit typed, input bit typed_has,
		input pix_res_t typed_res);
		pix_res_t r;
		bit       has;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.action    <= c.action;
		in_ch.corner_x0 <= c.corner_x0;
		in_ch.corner_y0 <= c.corner_y0;
		in_ch.corner_x1 <= c.corner_x1;
		in_ch.corner_y1 <= c.corner_y1;
		in_ch.fill_mode <= c.fill_mode;
		in_ch.color     <= c.color;
		do @(posedge clk); while (!in_ch.ready);
		if (!(c.action == ACT_STEP && ell_phase == ELL_IDLE))
			items_used++;
		has = ell_apply(c, r);
		if (typed) begin
			has = typed_has;
			r = typed_res;
		end
		if (has)
			pix_expected.push_back(r);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pix_expected.size() != 0);
	endtask

	function automatic int pick_span();
		int r;
		r = $urandom_range(99);
		if (r < 88)
			return $urandom_range(24);
		if (r < 99)
			return $urandom_range(200, 25);
		return $urandom_range(1023, 201);
	endfunction

	// one command: start, then advances until it finishes or is cut short
	task automatic run_ellipse(input bit pressure);
		draw_cmd_t c;
		int        sx, sy, x0, y0, limit, n;
		sx = pressure ? 160 : pick_span();
		sy = pressure ? 120 : pick_span();
		x0 = $urandom_range(1023 - sx);
		y0 = $urandom_range(1023 - sy);
		c = mk_cmd(ACT_START, x0, y0, x0 + sx, y0 + sy, $urandom_range(1), $urandom);
		if ($urandom_range(1)) begin
			c.corner_x0 = 10'(x0 + sx);
			c.corner_x1 = 10'(x0);
		end
		if ($urandom_range(1)) begin
			c.corner_y0 = 10'(y0 + sy);
			c.corner_y1 = 10'(y0);
		end
		send_cmd(c, 1'b0, 1'b0, '0);
		if (pressure)
			hold_reqs <= hold_reqs + 1;
		limit = (!pressure && $urandom_range(99) < 15) ? $urandom_range(8, 1) : 4000;
		n = 0;
		while (ell_phase != ELL_IDLE && n < limit) begin
			send_cmd(rand_step(), 1'b0, 1'b0, '0);
			n++;
		end
		// occasional extra advance, on an idle unit unless the run was cut short
		if ($urandom_range(99) < 20)
			send_cmd(rand_step(), 1'b0, 1'b0, '0);
	endtask

	// output side: stalls at random, plus the long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != holds_served) begin
			out_ch.ready <= 1'b0;
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		pix_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pix_expected.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				want = pix_expected.pop_front();
				check_field("emit", want.emit, out_ch.emit);
				check_field("done_res", want.done_res, out_ch.done_res);
				check_field("left_x", want.left_x, out_ch.left_x);
				check_field("right_x", want.right_x, out_ch.right_x);
				check_field("upper_row", want.upper_row, out_ch.upper_row);
				check_field("lower_row", want.lower_row, out_ch.lower_row);
				check_field("is_span", want.is_span, out_ch.is_span);
				check_field("pixel_color", want.pixel_color, out_ch.pixel_color);
				results_seen++;
				if (want.emit && want.is_span)
					spans_seen++;
				if (want.done_res)
					finishes_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[ellipse_rasterizer_unit] ERROR");
			$finish;
		end
	end

	initial begin
		pix_res_t none;
		draw_cmd_t c;
		int target;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_START;
		in_ch.corner_x0 = '0;
		in_ch.corner_y0 = '0;
		in_ch.corner_x1 = '0;
		in_ch.corner_y1 = '0;
		in_ch.fill_mode = 1'b0;
		in_ch.color = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		items_used = 0;
		results_seen = 0;
		spans_seen = 0;
		finishes_seen = 0;
		cycle_cnt = 0;
		tx_idle_pct = 13;
		rx_idle_pct = 52;
		hold_reqs = 0;
		holds_served = 0;
		hold_left = 0;
		none = '0;
		ell_reset();

		// directed table
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_cmd(ACT_START, 5, 5, 5, 5, 1, 32'h1234_5678), 1, 0, none);
		add_row(mk_cmd(ACT_STEP, 1023, 1023, 1023, 1023, 1, 32'hFFFF_FFFF), 1, 0, none);
		add_row(mk_cmd(ACT_START, 0, 0, 1023, 1023, 0, 32'hFFFF_FFFF), 0, 0, none);
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 1, 1,
			mk_pix(1, 0, 0, 1023, 511, 512, 0, 32'hFFFF_FFFF));
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 0, 0, none);
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 0, 0, none);
		// start while running drops the old command; swapped corners
		add_row(mk_cmd(ACT_START, 1023, 1023, 0, 0, 1, 32'h0000_0000), 0, 0, none);
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 1, 1,
			mk_pix(1, 0, 0, 1023, 511, 512, 1, 32'h0000_0000));
		// zero-width box
		add_row(mk_cmd(ACT_START, 10, 20, 10, 30, 0, 32'hA5A5_5A5A), 0, 0, none);
		for (int i = 0; i < 6; i++)
			add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 0, 0, none);
		// zero-height box, filled
		add_row(mk_cmd(ACT_START, 100, 40, 104, 40, 1, 32'h0F0F_F0F0), 0, 0, none);
		for (int i = 0; i < 5; i++)
			add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 0, 0, none);
		// tiny box at the range edge
		add_row(mk_cmd(ACT_START, 3, 1020, 0, 1023, 0, 32'h5A5A_A5A5), 0, 0, none);
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 0, 0, none);
		add_row(mk_cmd(ACT_STEP, 0, 0, 0, 0, 0, 0), 0, 0, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);
		drain_results();

		// random commands in three idling regimes
		for (int p = 0; p < 3; p++) begin
			tx_idle_pct = (p == 0) ? 13 : (p == 1) ? 52 : 0;
			rx_idle_pct <= (p == 0) ? 52 : (p == 1) ? 13 : 0;
			target = 350 * (p + 1);
			if (p == 2)
				run_ellipse(1'b1);
			while (items_used < target) begin
				case ($urandom_range(99)) inside
					[0:7]: send_cmd(rand_step(), 1'b0, 1'b0, '0);
					[8:13]: begin
						c = rand_step();
						c.action = ACT_START;
						c.corner_x1 = c.corner_x0;
						c.corner_y1 = c.corner_y0;
						send_cmd(c, 1'b0, 1'b0, '0);
					end
					default: run_ellipse(1'b0);
				endcase
			end
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (pix_expected.size() != 0) begin
			$error("%0d expected results never arrived", pix_expected.size());
			errors++;
		end
		$display("run covered %0d commands/steps, %0d results checked", items_used, results_seen);
		$display("  of which %0d filled spans and %0d finished ellipses", spans_seen,
			finishes_seen);
		if (errors == 0)
			$display("[ellipse_rasterizer_unit] OK");
		else
			$display("[ellipse_rasterizer_unit] ERROR");
		$finish;
	end

endmodule
